[rtl/b2da_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// b2da_pkg: shared definitions for the binary to decimal ASCII converter
// Widths, digit constants and the record passed from converter to emitter.
// ----------------------------------------------------------------------------
package b2da_pkg;

	// Width of the input field and the number of low bits that are converted.
	localparam int IN_W       = 64;
	localparam int VALUE_BITS = 64;

	// Decimal digits needed for VALUE_BITS bits: floor(VALUE_BITS * log10(2)) + 1.
	localparam int MAX_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
	localparam int DIGIT_W    = 4;
	localparam int BCD_W      = MAX_DIGITS * DIGIT_W;

	localparam int CHAR_W     = 6;
	localparam int COUNT_W    = 5;
	localparam int BIT_CNT_W  = $clog2(VALUE_BITS);
	localparam int IDX_W      = $clog2(MAX_DIGITS);

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(8'h30);

	// One finished conversion: packed BCD digits and the significant digit count.
	typedef struct packed {
		logic [BCD_W-1:0]   digits;
		logic [COUNT_W-1:0] count;
	} b2da_entry_t;

endpackage
`default_nettype wire

[rtl/b2da_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// b2da_in_if / b2da_out_if: valid/ready channels of the converter
// The input channel carries one binary value, the output channel one digit.
// ----------------------------------------------------------------------------
interface b2da_in_if;
	logic                       valid;
	logic                       ready;
	logic [b2da_pkg::IN_W-1:0]  value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

interface b2da_out_if;
	logic                          valid;
	logic                          ready;
	logic [b2da_pkg::CHAR_W-1:0]   digit_char;
	logic [b2da_pkg::COUNT_W-1:0]  digit_count;
	logic                          last;

	modport source (output valid, output digit_char, output digit_count, output last,
		input ready);
	modport sink   (input valid, input digit_char, input digit_count, input last,
		output ready);
endinterface
`default_nettype wire

[rtl/b2da_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// b2da_front: shift-and-add-3 binary to BCD converter
// Takes one value, converts it one bit per cycle and pushes the digit record.
// ----------------------------------------------------------------------------
module b2da_front (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	b2da_in_if.sink                     din,
	output logic                        push_valid,
	output b2da_pkg::b2da_entry_t       push_entry,
	input  wire logic                   push_ready
);

	typedef enum logic [1:0] {ST_IDLE, ST_CONV, ST_PUSH} state_t;

	state_t                              state_q;
	logic [b2da_pkg::VALUE_BITS-1:0]     bin_q;
	logic [b2da_pkg::BCD_W-1:0]          bcd_q;
	logic [b2da_pkg::BIT_CNT_W-1:0]      bit_cnt_q;
	logic [b2da_pkg::BCD_W-1:0]          bcd_adj;
	logic [b2da_pkg::BCD_W-1:0]          bcd_shift;
	logic [b2da_pkg::COUNT_W-1:0]        digit_cnt;

	// Every digit of five or more gets three added before the shift.
	always_comb begin
		for (int i = 0; i < b2da_pkg::MAX_DIGITS; i++) begin
			if (bcd_q[i*b2da_pkg::DIGIT_W +: b2da_pkg::DIGIT_W] >= 4'd5) begin
				bcd_adj[i*b2da_pkg::DIGIT_W +: b2da_pkg::DIGIT_W] =
					bcd_q[i*b2da_pkg::DIGIT_W +: b2da_pkg::DIGIT_W] + 4'd3;
			end else begin
				bcd_adj[i*b2da_pkg::DIGIT_W +: b2da_pkg::DIGIT_W] =
					bcd_q[i*b2da_pkg::DIGIT_W +: b2da_pkg::DIGIT_W];
			end
		end
	end

	assign bcd_shift = {bcd_adj[b2da_pkg::BCD_W-2:0], bin_q[b2da_pkg::VALUE_BITS-1]};

	// Position of the highest nonzero digit; zero still counts as one digit.
	always_comb begin
		digit_cnt = b2da_pkg::COUNT_W'(1);
		for (int i = 1; i < b2da_pkg::MAX_DIGITS; i++) begin
			if (bcd_q[i*b2da_pkg::DIGIT_W +: b2da_pkg::DIGIT_W] != '0) begin
				digit_cnt = b2da_pkg::COUNT_W'(i + 1);
			end
		end
	end

	assign din.ready         = (state_q == ST_IDLE);
	assign push_valid        = (state_q == ST_PUSH);
	assign push_entry.digits = bcd_q;
	assign push_entry.count  = digit_cnt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			bit_cnt_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (din.valid) begin
						bit_cnt_q <= b2da_pkg::BIT_CNT_W'(b2da_pkg::VALUE_BITS - 1);
						state_q   <= ST_CONV;
					end
				end
				ST_CONV: begin
					if (bit_cnt_q == '0) begin
						state_q <= ST_PUSH;
					end else begin
						bit_cnt_q <= bit_cnt_q - 1'b1;
					end
				end
				ST_PUSH: begin
					if (push_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && din.valid) begin
			bin_q <= din.value[b2da_pkg::VALUE_BITS-1:0];
			bcd_q <= '0;
		end else if (state_q == ST_CONV) begin
			bin_q <= {bin_q[b2da_pkg::VALUE_BITS-2:0], 1'b0};
			bcd_q <= bcd_shift;
		end
	end

endmodule
`default_nettype wire

[rtl/b2da_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// b2da_queue: small FIFO of finished conversions
// Decouples the converter from the digit emitter.
// ----------------------------------------------------------------------------
module b2da_queue (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   push_valid,
	input  b2da_pkg::b2da_entry_t       push_entry,
	output logic                        push_ready,
	output logic                        pop_valid,
	output b2da_pkg::b2da_entry_t       pop_entry,
	input  wire logic                   pop_ready
);

	b2da_pkg::b2da_entry_t           entries_q [b2da_pkg::QUEUE_DEPTH];
	logic [b2da_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [b2da_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [b2da_pkg::QPTR_W:0]       fill_q;
	logic                            do_push;
	logic                            do_pop;

	assign push_ready = (fill_q != (b2da_pkg::QPTR_W + 1)'(b2da_pkg::QUEUE_DEPTH));
	assign pop_valid  = (fill_q != '0);
	assign pop_entry  = entries_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule
`default_nettype wire

[rtl/b2da_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// b2da_back: digit emitter
// Walks a conversion record from its top digit down, one ASCII digit per word.
// ----------------------------------------------------------------------------
module b2da_back (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   pop_valid,
	input  b2da_pkg::b2da_entry_t       pop_entry,
	output logic                        pop_ready,
	b2da_out_if.source                  dout
);

	b2da_pkg::b2da_entry_t           entry_q;
	logic                            busy_q;
	logic [b2da_pkg::IDX_W-1:0]      idx_q;
	logic                            ovalid_q;
	logic [b2da_pkg::CHAR_W-1:0]     char_q;
	logic [b2da_pkg::COUNT_W-1:0]    count_q;
	logic                            last_q;
	logic                            adv;
	logic [b2da_pkg::DIGIT_W-1:0]    cur_digit;

	// The output register may be loaded when it is empty or being taken.
	assign adv       = !ovalid_q || dout.ready;
	assign pop_ready = !busy_q;
	assign cur_digit = entry_q.digits[idx_q*b2da_pkg::DIGIT_W +: b2da_pkg::DIGIT_W];

	assign dout.valid       = ovalid_q;
	assign dout.digit_char  = char_q;
	assign dout.digit_count = count_q;
	assign dout.last        = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			if (adv) begin
				ovalid_q <= busy_q;
			end
			if (!busy_q) begin
				busy_q <= pop_valid;
			end else if (adv && idx_q == '0) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!busy_q && pop_valid) begin
			entry_q <= pop_entry;
			idx_q   <= b2da_pkg::IDX_W'(pop_entry.count - 1'b1);
		end else if (busy_q && adv) begin
			char_q  <= b2da_pkg::ASCII_ZERO + b2da_pkg::CHAR_W'(cur_digit);
			count_q <= entry_q.count;
			last_q  <= (idx_q == '0);
			idx_q   <= idx_q - 1'b1;
		end
	end

endmodule
`default_nettype wire

[rtl/binary_to_decimal_ascii.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii: 64-bit binary to decimal ASCII text converter
// Converts each value to its decimal digits, most significant first, with no
// leading zeros, and sends one ASCII digit per output word.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Payload                              Words per value
//   din      sink       value[63:0]                          1
//   dout     source     digit_char[5:0], digit_count[4:0],   1 to 20
//                       last
//
// A value is converted by the shift-and-add-3 loop in one pass per converted
// bit, after the converter takes it and before it hands its digits on; the
// converter takes no new value until it has handed on the last one.
// Digits leave at one word per cycle while dout is ready, from a two-entry
// queue, so emission of one value overlaps the conversion of the next.
// Reset clears all control state; no value is in flight afterwards.
// A stall on dout fills the queue and then holds the converter, and din
// stays not ready until the converter is free again.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii (
	input  wire logic   clk,
	input  wire logic   arst_n,
	b2da_in_if.sink     din,
	b2da_out_if.source  dout
);

	// Records move from the converter into the queue and from the queue to the
	// emitter with a simple valid/ready pair on each side.
	logic                       push_valid;
	logic                       push_ready;
	b2da_pkg::b2da_entry_t      push_entry;
	logic                       pop_valid;
	logic                       pop_ready;
	b2da_pkg::b2da_entry_t      pop_entry;

	// The converter: takes a value and forms its BCD digits and digit count.
	b2da_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.din        (din),
		.push_valid (push_valid),
		.push_entry (push_entry),
		.push_ready (push_ready)
	);

	// The queue lets the converter start on the next value while the emitter
	// is still sending digits of the previous one.
	b2da_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_entry (push_entry),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_entry  (pop_entry),
		.pop_ready  (pop_ready)
	);

	// The emitter walks each record from the top significant digit down and
	// marks the final digit with last.
	b2da_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_entry (pop_entry),
		.pop_ready (pop_ready),
		.dout      (dout)
	);

endmodule
`default_nettype wire

[rtl/b2da_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// b2da_checker: port-level checks for the decimal ASCII converter
// Watches the output channel over time and is bound to the top level.
// ----------------------------------------------------------------------------
module b2da_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          out_valid,
	input wire logic                          out_ready,
	input wire logic [b2da_pkg::CHAR_W-1:0]   digit_char,
	input wire logic [b2da_pkg::COUNT_W-1:0]  digit_count,
	input wire logic                          last
);

	// A stalled word keeps its payload.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(digit_char)
			&& $stable(digit_count) && $stable(last))
		else $error("output word changed while stalled");

	// Every word carries a decimal digit character.
	a_digit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> digit_char >= b2da_pkg::ASCII_ZERO
			&& digit_char <= b2da_pkg::CHAR_W'(8'h39))
		else $error("digit character out of range");

	// A one-digit conversion is its own final digit.
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && digit_count == b2da_pkg::COUNT_W'(1) |-> last)
		else $error("single digit not marked last");

	// Digits of one value all report the same count.
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last ##1 out_valid |->
			digit_count == $past(digit_count))
		else $error("digit count changed within one value");

endmodule

bind binary_to_decimal_ascii b2da_checker u_b2da_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (dout.valid),
	.out_ready   (dout.ready),
	.digit_char  (dout.digit_char),
	.digit_count (dout.digit_count),
	.last        (dout.last)
);
`default_nettype wire
